FILE: src/b64d_pkg.sv
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Queue between classifier and decoder; depth must be a power of two
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_SYM = 2'd0,
        KIND_PAD = 2'd1,
        KIND_BAD = 2'd2
    } t_char_kind;

    typedef enum logic [2:0] {
        MODE_DECODE = 3'b001,
        MODE_PAD    = 3'b010,
        MODE_IGNORE = 3'b100
    } t_decode_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        t_char_kind kind;
        logic [5:0] sym;
        logic       last_char;
    } t_class_item;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  decoded_byte;
        logic        end_of_text;
        logic        bad_length;
        logic [15:0] chars_used;
    } t_out_item;

endpackage

FILE: src/b64d_front.sv
module b64d_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  b64d_pkg::t_in_item   i_in_item,
    output logic                 o_q_push,
    input  logic                 i_q_ready,
    output b64d_pkg::t_class_item o_q_item
);

    logic                  r_valid;
    b64d_pkg::t_class_item r_item;
    b64d_pkg::t_class_item n_item;
    logic [7:0]            c;

    assign c = i_in_item.char_code;

    // alphabet lookup: letters, digits, '+', '/', and the pad character
    always_comb begin
        n_item.kind      = b64d_pkg::KIND_BAD;
        n_item.sym       = 6'd0;
        n_item.last_char = i_in_item.last_char;
        unique if (c == b64d_pkg::PAD_CHAR) begin
            n_item.kind = b64d_pkg::KIND_PAD;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            n_item.kind = b64d_pkg::KIND_SYM;
            n_item.sym  = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            n_item.kind = b64d_pkg::KIND_SYM;
            n_item.sym  = 6'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            n_item.kind = b64d_pkg::KIND_SYM;
            n_item.sym  = 6'(c + 8'd4);
        end else if (c == 8'h2B) begin
            n_item.kind = b64d_pkg::KIND_SYM;
            n_item.sym  = 6'd62;
        end else if (c == 8'h2F) begin
            n_item.kind = b64d_pkg::KIND_SYM;
            n_item.sym  = 6'd63;
        end else begin
            n_item.kind = b64d_pkg::KIND_BAD;
        end
    end

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_q_push   = r_valid && i_q_ready;
    assign o_q_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: src/b64d_queue.sv
module b64d_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_ready,
    input  b64d_pkg::t_class_item i_item,
    input  logic                  i_pop,
    output logic                  o_valid,
    output b64d_pkg::t_class_item o_item
);

    b64d_pkg::t_class_item                r_mem [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [b64d_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [b64d_pkg::QUEUE_CNT_W-1:0]     r_count;

    assign o_ready = r_count < b64d_pkg::QUEUE_CNT_W'(b64d_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: src/b64d_back.sv
module b64d_back #(
    parameter logic [15:0] COUNT_LIMIT = 16'hFFFF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  b64d_pkg::t_class_item i_q_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output b64d_pkg::t_out_item   o_out_item
);

    b64d_pkg::t_decode_mode r_mode;
    b64d_pkg::t_decode_mode n_mode;
    logic [1:0]             r_phase;
    logic [1:0]             n_phase;
    logic [7:0]             r_partial;
    logic [7:0]             n_partial;
    logic [15:0]            r_count;
    logic [15:0]            n_count;
    logic                   r_out_valid;
    b64d_pkg::t_out_item    r_out;
    b64d_pkg::t_out_item    n_out;
    logic                   can_take;
    logic                   have;
    logic                   step;
    logic [7:0]             byte_val;
    logic [5:0]             v;

    assign can_take = !r_out_valid || i_out_ready;
    assign o_q_pop  = i_q_valid && can_take;
    assign v        = i_q_item.sym;

    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_partial = r_partial;
        n_count   = r_count;
        have      = 1'b0;
        step      = 1'b0;
        byte_val  = 8'd0;

        unique case (r_mode)
            b64d_pkg::MODE_DECODE,
            b64d_pkg::MODE_PAD: begin
                if (i_q_item.kind == b64d_pkg::KIND_PAD) begin
                    // pad at quad start is not consumed
                    if (r_phase == 2'd0) begin
                        n_mode = b64d_pkg::MODE_IGNORE;
                    end else begin
                        step   = 1'b1;
                        n_mode = (r_phase == 2'd3) ? b64d_pkg::MODE_IGNORE
                                                   : b64d_pkg::MODE_PAD;
                    end
                end else if (i_q_item.kind == b64d_pkg::KIND_SYM &&
                             r_mode == b64d_pkg::MODE_DECODE) begin
                    step = 1'b1;
                    unique case (r_phase)
                        2'd0: begin
                            n_partial = {v, 2'b00};
                        end
                        2'd1: begin
                            have      = 1'b1;
                            byte_val  = r_partial | {6'd0, v[5:4]};
                            n_partial = {v[3:0], 4'd0};
                        end
                        2'd2: begin
                            have      = 1'b1;
                            byte_val  = r_partial | {4'd0, v[5:2]};
                            n_partial = {v[1:0], 6'd0};
                        end
                        2'd3: begin
                            have      = 1'b1;
                            byte_val  = r_partial | {2'd0, v};
                            n_partial = 8'd0;
                        end
                    endcase
                end else begin
                    n_mode = b64d_pkg::MODE_IGNORE;
                end
            end
            b64d_pkg::MODE_IGNORE: begin
            end
            default: begin
            end
        endcase

        if (step) begin
            n_phase = r_phase + 2'd1;
            if (r_count < COUNT_LIMIT) begin
                n_count = r_count + 16'd1;
            end
        end

        n_out.byte_valid   = have;
        n_out.decoded_byte = byte_val;
        n_out.end_of_text  = i_q_item.last_char;
        n_out.bad_length   = i_q_item.last_char && (n_phase != 2'd0);
        n_out.chars_used   = i_q_item.last_char ? n_count : 16'd0;

        if (i_q_item.last_char) begin
            n_mode    = b64d_pkg::MODE_DECODE;
            n_phase   = 2'd0;
            n_partial = 8'd0;
            n_count   = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= b64d_pkg::MODE_DECODE;
            r_phase     <= 2'd0;
            r_partial   <= 8'd0;
            r_count     <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_mode    <= n_mode;
                r_phase   <= n_phase;
                r_partial <= n_partial;
                r_count   <= n_count;
            end
            if (can_take) begin
                r_out_valid <= o_q_pop && (have || i_q_item.last_char);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_item.last_char) |=>
            (r_phase == 2'd0 && r_count == 16'd0 && r_mode == b64d_pkg::MODE_DECODE))
        else $error("state not cleared after last character");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_LIMIT)
        else $error("consumed count above limit");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.byte_valid || r_out.end_of_text))
        else $error("result with neither byte nor end");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.byte_valid) |-> (r_out.decoded_byte == 8'd0))
        else $error("stale byte on result without byte");

endmodule

FILE: src/base64_stream_decoder_core.sv
// A result reaches o_out_valid through the classifier register (loaded at the input
// transfer edge), the queue and the decoder output register. Throughput: one character
// per cycle while i_out_ready holds; the decoder state update is the loop.
// Characters that complete no byte and are not last give no result.
// Reset (i_rst_n low, synchronous) empties the queue and clears decoder state.
module base64_stream_decoder_core #(
    parameter int unsigned MAX_CHARS = 65535
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  b64d_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output b64d_pkg::t_out_item o_out_item
);

    localparam logic [15:0] CountLimit =
        (MAX_CHARS > 32'd65535) ? 16'hFFFF : 16'(MAX_CHARS);

    logic                  push;
    logic                  q_ready;
    b64d_pkg::t_class_item push_item;
    logic                  pop;
    logic                  q_valid;
    b64d_pkg::t_class_item pop_item;

    b64d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_q_push   (push),
        .i_q_ready  (q_ready),
        .o_q_item   (push_item)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    b64d_back #(
        .COUNT_LIMIT (CountLimit)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (pop),
        .i_q_item    (pop_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: dv/tb_base64_stream_decoder_core.sv
module tb_base64_stream_decoder_core;
    import b64d_pkg::*;

    localparam int unsigned MAX_CHARS    = 65535;
    localparam int unsigned CNT_CAP      = (MAX_CHARS > 65535) ? 65535 : MAX_CHARS;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned RAND_CHARS   = 500;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    base64_stream_decoder_core #(
        .MAX_CHARS(MAX_CHARS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Decoder state mirror and expected result store
    // ---------------------------------------------------------------
    logic [1:0]   quad_pos  = '0;
    logic [7:0]   part_bits = '0;
    t_decode_mode dec_mode  = MODE_DECODE;
    logic [15:0]  used_cnt  = '0;

    t_out_item    result_q[$];
    t_in_item     pending_chars[$];
    int unsigned  total_cnt = 0;
    int unsigned  sent_cnt  = 0;
    int unsigned  err_cnt   = 0;
    int unsigned  calm_left[2];

    function automatic logic [6:0] sym_of(logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
        if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 26);
        if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 52);
        if (c == 8'h2B) return 7'd62;
        if (c == 8'h2F) return 7'd63;
        return 7'd64;
    endfunction

    function automatic logic [7:0] sym_char(int unsigned v);
        if (v < 26) return 8'(8'h41 + v);
        if (v < 52) return 8'(8'h61 + v - 26);
        if (v < 62) return 8'(8'h30 + v - 52);
        if (v == 62) return 8'h2B;
        return 8'h2F;
    endfunction

    task automatic bump_count();
        if (used_cnt < CNT_CAP) used_cnt++;
        quad_pos++;
    endtask

    // '=' is only taken while the quad is open
    task automatic take_pad();
        if (quad_pos == 2'd0) begin
            dec_mode = MODE_IGNORE;
        end else begin
            bump_count();
            dec_mode = (quad_pos == 2'd0) ? MODE_IGNORE : MODE_PAD;
        end
    endtask

    task automatic decode_char(t_in_item it);
        logic [6:0] v;
        logic       have;
        logic [7:0] b;
        t_out_item  res;
        have = 1'b0;
        b    = '0;
        case (dec_mode)
            MODE_DECODE: begin
                if (it.char_code == PAD_CHAR) begin
                    take_pad();
                end else begin
                    v = sym_of(it.char_code);
                    if (v[6]) begin
                        dec_mode = MODE_IGNORE;
                    end else begin
                        case (quad_pos)
                            2'd0: part_bits = {v[5:0], 2'b00};
                            2'd1: begin
                                b         = part_bits | {6'b0, v[5:4]};
                                part_bits = {v[3:0], 4'b0};
                                have      = 1'b1;
                            end
                            2'd2: begin
                                b         = part_bits | {4'b0, v[5:2]};
                                part_bits = {v[1:0], 6'b0};
                                have      = 1'b1;
                            end
                            default: begin
                                b         = part_bits | {2'b0, v[5:0]};
                                part_bits = '0;
                                have      = 1'b1;
                            end
                        endcase
                        bump_count();
                    end
                end
            end
            MODE_PAD: begin
                if (it.char_code == PAD_CHAR) take_pad();
                else dec_mode = MODE_IGNORE;
            end
            default: ;
        endcase
        if (have || it.last_char) begin
            res.byte_valid   = have;
            res.decoded_byte = b;
            res.end_of_text  = it.last_char;
            res.bad_length   = it.last_char && (quad_pos != 2'd0);
            res.chars_used   = it.last_char ? used_cnt : 16'd0;
            result_q.push_back(res);
        end
        if (it.last_char) begin
            quad_pos  = '0;
            part_bits = '0;
            dec_mode  = MODE_DECODE;
            used_cnt  = '0;
        end
    endtask

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (result_q.size() == 0) begin
            report_error($sformatf("unexpected result %p", got));
        end else begin
            want = result_q.pop_front();
            if (got.byte_valid !== want.byte_valid)
                report_error($sformatf("byte_valid got %0d exp %0d",
                    got.byte_valid, want.byte_valid));
            if (got.decoded_byte !== want.decoded_byte)
                report_error($sformatf("decoded_byte got %02h exp %02h",
                    got.decoded_byte, want.decoded_byte));
            if (got.end_of_text !== want.end_of_text)
                report_error($sformatf("end_of_text got %0d exp %0d",
                    got.end_of_text, want.end_of_text));
            if (got.bad_length !== want.bad_length)
                report_error($sformatf("bad_length got %0d exp %0d",
                    got.bad_length, want.bad_length));
            if (got.chars_used !== want.chars_used)
                report_error($sformatf("chars_used got %0d exp %0d",
                    got.chars_used, want.chars_used));
        end
    endtask

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int unsigned pick_gap(int side);
        int unsigned r;
        if (calm_left[side] != 0) begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm_left[side] = $urandom_range(20, 120);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus text builders
    // ---------------------------------------------------------------
    task automatic add_char(logic [7:0] c, logic last);
        t_in_item it;
        it.char_code = c;
        it.last_char = last;
        pending_chars.push_back(it);
        total_cnt++;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
    endtask

    task automatic add_random_text();
        logic [7:0]  txt[$];
        int unsigned kind;
        int unsigned r;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            // well-formed body, varied tail
            repeat (4 * $urandom_range(0, 3)) txt.push_back(sym_char($urandom_range(0, 63)));
            case ($urandom_range(0, 5))
                0: ;
                1: begin
                    repeat (2) txt.push_back(sym_char($urandom_range(0, 63)));
                    repeat (2) txt.push_back(PAD_CHAR);
                end
                2: begin
                    repeat (3) txt.push_back(sym_char($urandom_range(0, 63)));
                    txt.push_back(PAD_CHAR);
                end
                3: repeat ($urandom_range(1, 3)) txt.push_back(sym_char($urandom_range(0, 63)));
                4: begin
                    repeat ($urandom_range(1, 2)) txt.push_back(sym_char($urandom_range(0, 63)));
                    repeat ($urandom_range(1, 4)) txt.push_back(PAD_CHAR);
                end
                default: begin
                    txt.push_back(sym_char($urandom_range(0, 63)));
                    txt.push_back(PAD_CHAR);
                    txt.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 85) begin
            repeat ($urandom_range(1, 10)) begin
                r = $urandom_range(0, 99);
                if (r < 70) txt.push_back(sym_char($urandom_range(0, 63)));
                else if (r < 85) txt.push_back(PAD_CHAR);
                else txt.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
        end
        if (txt.size() == 0) txt.push_back(sym_char($urandom_range(0, 63)));
        foreach (txt[i]) add_char(txt[i], i == txt.size() - 1);
    endtask

    // ---------------------------------------------------------------
    // Input driver
    // ---------------------------------------------------------------
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && in_ready) begin
                decode_char(in_item);
                sent_cnt++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_chars.size() != 0) begin
                    in_item  <= pending_chars.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= pick_gap(0);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output monitor
    // ---------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && out_ready) check_result(out_item);
            if (stall_left != 0) begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                out_ready <= 1'b1;
                if (out_valid && out_ready) stall_left <= pick_gap(1);
            end
        end
    end

    int unsigned cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int unsigned rand_start;

        // directed texts
        add_text("TWFu");            // one full quad
        add_text("/+8=");            // top symbols, pad closes the quad
        add_text("AA===");           // two pads, then a stray one ignored
        add_text("=");               // pad at quad start, nothing consumed
        add_text("QQ=x");            // non-pad char while in padding
        add_char(8'h5A, 1'b0);
        add_char(8'h7A, 1'b0);
        add_char(8'hFF, 1'b1);       // outside alphabet, last
        add_char(8'h41, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(8'h61, 1'b1);       // ignored char as last

        rand_start = total_cnt;
        while (total_cnt - rand_start < RAND_CHARS) add_random_text();

        while (sent_cnt != total_cnt || result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
